/* src/ssbs_pkg.sv */
`timescale 1ns / 1ps

package ssbs_pkg;

   localparam int DATA_W           = 32;
   localparam int POS_W            = 4;
   localparam int STATUS_W         = 3;
   localparam int CAPACITY_DEFAULT = 16;

   typedef enum logic [STATUS_W-1:0] {
      ST_LOADED   = 3'd0,
      ST_FOUND    = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOSET    = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [POS_W-1:0] position;
   } rsp_type;

endpackage

/* src/sorted_set_binary_search_unit.sv */
`timescale 1ns / 1ps

// Channel    Handshake             Payload
// ---------  --------------------  ------------------------------------------
// request    start & !busy         req_type, req_value (signed), req_last
// response   rsp_valid (1 cycle)   rsp_status, rsp_position
//
// A load that starts no sort leaves busy low, so loads may come back to back.
// A load with req_last and two or more held elements sorts the set in the
// memory by insertion, and busy stays high until the sort is done.
// A search that is rejected (no set, out of range) answers without raising
// busy; else it makes at most floor(log2(n)) + 1 probes through the memory.
// A response beat shows in the cycle after its decision; the receiver cannot
// stall it. Reset clears control state; the element memory is not cleared.

module sorted_set_binary_search_unit
   import ssbs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_type,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_last,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [POS_W-1:0]         rsp_position
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic              ram_we;
   logic [IW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [IW-1:0]     ram_raddr;
   logic [DATA_W-1:0] ram_rdata;
   rsp_type           rsp_beat;

   // response register: one beat per request, never held
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_position_ff, rsp_position_in;

   // sorted element store
   ssbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_elements (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // load, sort and search sequencing
   ssbs_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .req_value (req_value),
      .req_last  (req_last),
      .busy      (busy),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_beat  (rsp_beat)
   );

   // capture the decision; drop position to zero on anything but a hit
   always_comb begin
      rsp_valid_in    = rsp_beat.valid;
      rsp_status_in   = rsp_beat.status;
      rsp_position_in = (rsp_beat.status == ST_FOUND) ? rsp_beat.position : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;

endmodule

/* src/ssbs_ram.sv */
`timescale 1ns / 1ps

module ssbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/ssbs_ctrl.sv */
`timescale 1ns / 1ps

module ssbs_ctrl
   import ssbs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic                                         req_type,
   input  logic signed [DATA_W-1:0]                     req_value,
   input  logic                                         req_last,
   output logic                                         busy,
   output logic                                         ram_we,
   output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] ram_waddr,
   output logic [DATA_W-1:0]                            ram_wdata,
   output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] ram_raddr,
   input  logic [DATA_W-1:0]                            ram_rdata,
   output rsp_type                                      rsp_beat
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_SORT_START = 6'b000010,
      S_SORT_CUR   = 6'b000100,
      S_SORT_SHIFT = 6'b001000,
      S_SORT_PLACE = 6'b010000,
      S_PROBE      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]            count_ff, count_in;
   logic                     set_ready_ff, set_ready_in;
   logic                     loading_ff, loading_in;
   logic signed [DATA_W-1:0] min_ff, min_in;
   logic signed [DATA_W-1:0] max_ff, max_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CW-1:0]            i_ff, i_in;
   logic [IW-1:0]            j_ff, j_in;
   logic [IW-1:0]            lo_ff, lo_in;
   logic [IW-1:0]            hi_ff, hi_in;
   logic [IW-1:0]            mid_ff, mid_in;

   logic                     accept;
   logic [CW-1:0]            base_count;
   logic                     fits;
   logic [CW-1:0]            new_count;
   logic [IW-1:0]            hi_start;
   logic [IW-1:0]            mid_m1;
   logic [IW-1:0]            mid_p1;
   logic [IW:0]              sum_lo;
   logic [IW:0]              sum_hi;
   logic [CW-1:0]            i_next;
   logic                     sort_done;
   logic signed [DATA_W-1:0] rdata_s;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && (state_ff == S_IDLE);
   assign base_count = loading_ff ? count_ff : '0;
   assign fits       = (base_count < CW'(CAPACITY));
   assign new_count  = base_count + CW'(fits);
   assign hi_start   = count_ff[IW-1:0] - IW'(1);
   assign mid_m1     = mid_ff - IW'(1);
   assign mid_p1     = mid_ff + IW'(1);
   assign sum_lo     = {1'b0, lo_ff} + {1'b0, mid_m1};
   assign sum_hi     = {1'b0, mid_p1} + {1'b0, hi_ff};
   assign i_next     = i_ff + CW'(1);
   assign sort_done  = (i_next == count_ff);
   assign rdata_s    = signed'(ram_rdata);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      set_ready_in    = set_ready_ff;
      loading_in      = loading_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      cur_in          = cur_ff;
      key_in          = key_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      ram_we          = 1'b0;
      ram_waddr       = j_ff;
      ram_wdata       = cur_ff;
      ram_raddr       = mid_ff;
      rsp_beat.valid    = 1'b0;
      rsp_beat.status   = ST_LOADED;
      rsp_beat.position = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_type == REQ_LOAD) begin
               ram_we          = fits;
               ram_waddr       = base_count[IW-1:0];
               ram_wdata       = req_value;
               count_in        = new_count;
               set_ready_in    = req_last && (new_count != '0);
               loading_in      = !req_last;
               if (fits && (!loading_ff || req_value < min_ff)) begin
                  min_in = req_value;
               end
               if (fits && (!loading_ff || req_value > max_ff)) begin
                  max_in = req_value;
               end
               rsp_beat.valid  = 1'b1;
               rsp_beat.status = fits ? ST_LOADED : ST_OVERFLOW;
               if (req_last && new_count > CW'(1)) begin
                  i_in     = CW'(1);
                  state_in = S_SORT_START;
               end
            end else if (accept) begin
               if (!set_ready_ff) begin
                  rsp_beat.valid  = 1'b1;
                  rsp_beat.status = ST_NOSET;
               end else if (req_value < min_ff || req_value > max_ff) begin
                  rsp_beat.valid  = 1'b1;
                  rsp_beat.status = ST_RANGE;
               end else begin
                  key_in    = req_value;
                  lo_in     = '0;
                  hi_in     = hi_start;
                  mid_in    = hi_start >> 1;
                  ram_raddr = hi_start >> 1;
                  state_in  = S_PROBE;
               end
            end
         end
         S_SORT_START: begin
            ram_raddr = i_ff[IW-1:0];
            state_in  = S_SORT_CUR;
         end
         S_SORT_CUR: begin
            cur_in    = rdata_s;
            j_in      = i_ff[IW-1:0];
            ram_raddr = i_ff[IW-1:0] - IW'(1);
            state_in  = S_SORT_SHIFT;
         end
         S_SORT_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            if (rdata_s > cur_ff) begin
               // move the larger neighbor up one slot
               ram_wdata = ram_rdata;
               j_in      = j_ff - IW'(1);
               if (j_ff == IW'(1)) begin
                  state_in = S_SORT_PLACE;
               end else begin
                  ram_raddr = j_ff - IW'(2);
               end
            end else begin
               ram_wdata = cur_ff;
               i_in      = i_next;
               ram_raddr = i_next[IW-1:0];
               state_in  = sort_done ? S_IDLE : S_SORT_CUR;
            end
         end
         S_SORT_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = cur_ff;
            i_in      = i_next;
            ram_raddr = i_next[IW-1:0];
            state_in  = sort_done ? S_IDLE : S_SORT_CUR;
         end
         S_PROBE: begin
            if (rdata_s == key_ff) begin
               rsp_beat.valid    = 1'b1;
               rsp_beat.status   = ST_FOUND;
               rsp_beat.position = POS_W'(mid_ff);
               state_in          = S_IDLE;
            end else if (rdata_s > key_ff) begin
               if (mid_ff == lo_ff) begin
                  rsp_beat.valid  = 1'b1;
                  rsp_beat.status = ST_NOTFOUND;
                  state_in        = S_IDLE;
               end else begin
                  hi_in     = mid_m1;
                  mid_in    = sum_lo[IW:1];
                  ram_raddr = sum_lo[IW:1];
               end
            end else begin
               if (mid_ff == hi_ff) begin
                  rsp_beat.valid  = 1'b1;
                  rsp_beat.status = ST_NOTFOUND;
                  state_in        = S_IDLE;
               end else begin
                  lo_in     = mid_p1;
                  mid_in    = sum_hi[IW:1];
                  ram_raddr = sum_hi[IW:1];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         set_ready_ff <= 1'b0;
         loading_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         set_ready_ff <= set_ready_in;
         loading_ff   <= loading_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      max_ff <= max_in;
      cur_ff <= cur_in;
      key_ff <= key_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
   end

`ifndef SYNTHESIS
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register lost its one-hot code");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_probe_set: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> set_ready_ff && !loading_ff)
      else $error("probe without a complete set");

   a_probe_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> lo_ff <= mid_ff && mid_ff <= hi_ff)
      else $error("midpoint outside search window");

   a_sort_write: assert property (@(posedge clock) disable iff (reset)
      ram_we && state_ff != S_IDLE |-> CW'(ram_waddr) < count_ff)
      else $error("sort write beyond the loaded set");
`endif

endmodule

/* tb/sorted_set_binary_search_unit_test.sv */
`timescale 1ns / 1ps

module sorted_set_binary_search_unit_test;
   import ssbs_pkg::*;

   localparam int CAPACITY       = CAPACITY_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;  // longer than a full 16-element sort
   localparam int DRAIN_CYCLES   = 200;   // covers a sort still running after its beat
   localparam int MAX_REPORTS    = 10;
   localparam int ITEM_TARGET    = 800;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct {
      status_type       status;
      logic [POS_W-1:0] position;
   } search_result_type;

   // Tracks the held set and the queue of responses still owed by the block.
   class sorted_set_tracker;
      logic signed [DATA_W-1:0] held [CAPACITY];
      int                       held_count;
      bit                       set_ready;
      bit                       loading;
      search_result_type        owed [$];
      int                       failures;
      int                       reports;

      function new();
         held_count = 0;
         set_ready  = 1'b0;
         loading    = 1'b0;
         failures   = 0;
         reports    = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Insertion sort, ascending as signed values.
      function void sort_held();
         logic signed [DATA_W-1:0] cur;
         int                       j;
         for (int i = 1; i < held_count; i++) begin
            cur = held[i];
            j   = i;
            while (j > 0 && held[j-1] > cur) begin
               held[j] = held[j-1];
               j--;
            end
            held[j] = cur;
         end
      endfunction

      function search_result_type lookup(logic signed [DATA_W-1:0] key);
         search_result_type r;
         int                lo;
         int                hi;
         int                mid;
         r.status   = ST_NOTFOUND;
         r.position = '0;
         if (!set_ready || held_count == 0) begin
            r.status = ST_NOSET;
            return r;
         end
         if (key < held[0] || key > held[held_count-1]) begin
            r.status = ST_RANGE;
            return r;
         end
         lo  = 0;
         hi  = held_count - 1;
         mid = (lo + hi) / 2;
         while (lo <= hi && held[mid] != key) begin
            if (held[mid] > key)
               hi = mid - 1;
            else
               lo = mid + 1;
            if (lo > hi)
               break;
            mid = (lo + hi) / 2;
         end
         if (held[mid] == key) begin
            r.status   = ST_FOUND;
            r.position = mid[POS_W-1:0];
         end
         return r;
      endfunction

      function void note_request(req_kind_type kind, logic signed [DATA_W-1:0] value,
                                 logic last);
         search_result_type r;
         r.status   = ST_LOADED;
         r.position = '0;
         if (kind == REQ_LOAD) begin
            if (!loading) begin
               held_count = 0;
               set_ready  = 1'b0;
               loading    = 1'b1;
            end
            if (held_count < CAPACITY) begin
               held[held_count] = value;
               held_count++;
            end else begin
               r.status = ST_OVERFLOW;
            end
            if (last) begin
               sort_held();
               set_ready = (held_count > 0);
               loading   = 1'b0;
            end
         end else begin
            r = lookup(value);
         end
         owed.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position);
         search_result_type want;
         if (owed.size() == 0) begin
            failures++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%t unexpected response: status %0d position %0d",
                        $realtime, status, position);
            end
            return;
         end
         want = owed.pop_front();
         if (status !== want.status || position !== want.position) begin
            failures++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%t response mismatch: expected status %0d position %0d, got %0d %0d",
                        $realtime, want.status, want.position, status, position);
            end
         end
      endfunction
   endclass

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     start        = 1'b0;
   logic                     busy;
   logic                     req_type     = REQ_LOAD;
   logic signed [DATA_W-1:0] req_value    = '0;
   logic                     req_last     = 1'b0;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic [POS_W-1:0]         rsp_position;

   sorted_set_tracker        tracker;
   int                       items_sent   = 0;
   int                       idle_cycles  = 0;
   // Values of the set being built, used to aim search keys at real elements.
   logic signed [DATA_W-1:0] loaded_values [$];

   sorted_set_binary_search_unit #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_value   (req_value),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_position(rsp_position)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Monitor: everything is read at the rising edge, before any update of
   // this edge lands, so it sees exactly what the block sampled.
   always @(posedge clock) begin
      if (!reset) begin
         // Check the response first: it always belongs to an earlier beat.
         if (rsp_valid)
            tracker.check_response(rsp_status, rsp_position);
         if (start && !busy)
            tracker.note_request(req_kind_type'(req_type), req_value, req_last);
         // Count cycles with no beat on either side; give up past the limit.
         if (rsp_valid || (start && !busy))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t watchdog expired with %0d responses owed", $realtime,
                     tracker.pending());
            $display("** sorted_set_binary_search_unit: FAILED **");
            $finish;
         end
      end
   end

   // Present one beat and hold it until the block takes it. With chance
   // idle_pct, drop start first and scramble the payload.
   task automatic send_beat(req_kind_type kind, logic signed [DATA_W-1:0] value,
                            logic last, int idle_pct);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start     <= 1'b0;
         req_value <= $urandom;
         req_last  <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start     <= 1'b1;
      req_type  <= kind;
      req_value <= value;
      req_last  <= last;
      // Wait for an edge where busy was low: that edge takes the beat.
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // Element values: a narrow pool makes duplicates likely, wide ones cover every bit.
   function automatic logic signed [DATA_W-1:0] pick_element(int mode);
      logic signed [DATA_W-1:0] v;
      v = $urandom;
      if (mode == 0)
         v = int'($urandom_range(0, 16)) - 8;
      else if (mode == 2) begin
         case ($urandom_range(0, 4))
            0: v = VALUE_MIN;
            1: v = VALUE_MAX;
            2: v = VALUE_MIN + 1;
            3: v = VALUE_MAX - 1;
            default: ;
         endcase
      end
      return v;
   endfunction

   // Search keys: mostly held elements, then near misses, random and extremes.
   function automatic logic signed [DATA_W-1:0] pick_key();
      int                       pick;
      int                       n;
      logic signed [DATA_W-1:0] k;
      pick = $urandom_range(0, 99);
      n    = loaded_values.size();
      k    = $urandom;
      if (n > 0) begin
         if (pick < 50)
            k = loaded_values[$urandom_range(0, n - 1)];
         else if (pick < 70)
            k = loaded_values[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      end
      if (pick >= 90)
         k = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      return k;
   endfunction

   // One set and a run of searches against it. A few sets overflow, a few
   // leave out last so the next set keeps growing, a few get searched while
   // still loading.
   task automatic load_and_probe(int idle_pct);
      int                       r;
      int                       size;
      int                       mode;
      int                       probe_at;
      bit                       drop_last;
      logic signed [DATA_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 8)
         size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      else if (r < 20)
         size = 1;
      else
         size = $urandom_range(2, CAPACITY);
      mode      = $urandom_range(0, 2);
      drop_last = ($urandom_range(0, 19) == 0);
      probe_at  = (size > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, size - 1) : -1;
      loaded_values.delete();
      for (int i = 0; i < size; i++) begin
         v = pick_element(mode);
         if (loaded_values.size() < CAPACITY)
            loaded_values.push_back(v);
         send_beat(REQ_LOAD, v, (i == size - 1) && !drop_last, idle_pct);
         if (i + 1 == probe_at)
            send_beat(REQ_SEARCH, pick_key(), 1'($urandom_range(0, 1)), idle_pct);
      end
      repeat ($urandom_range(1, 8))
         send_beat(REQ_SEARCH, pick_key(), 1'($urandom_range(0, 1)), idle_pct);
   endtask

   task automatic run_directed();
      logic signed [DATA_W-1:0] first_set [CAPACITY] = '{
         5, -3, 5, 100000, -2000000000, 2000000000, 12, 0,
         -1, 7, 7, 64, -64, 1073741824, -1073741824, 3
      };
      // Search before any set exists; last is ignored on searches.
      send_beat(REQ_SEARCH, 0, 1'b1, 0);
      // Fill to capacity, probing once while the set is still loading.
      for (int i = 0; i < CAPACITY; i++) begin
         send_beat(REQ_LOAD, first_set[i], 1'b0, 0);
         if (i == 2)
            send_beat(REQ_SEARCH, first_set[0], 1'b0, 0);
      end
      // One beat too many: dropped, but its last still closes the set.
      send_beat(REQ_LOAD, VALUE_MAX, 1'b1, 0);
      send_beat(REQ_SEARCH, VALUE_MIN, 1'b0, 0);    // below the smallest
      send_beat(REQ_SEARCH, VALUE_MAX, 1'b0, 0);    // above the largest
      send_beat(REQ_SEARCH, 7, 1'b0, 0);            // duplicate value
      send_beat(REQ_SEARCH, 4, 1'b0, 0);            // gap inside the range
      send_beat(REQ_SEARCH, -2000000000, 1'b0, 0);  // smallest element
      // New set of one element discards the old one.
      send_beat(REQ_LOAD, VALUE_MIN, 1'b1, 0);
      send_beat(REQ_SEARCH, VALUE_MIN, 1'b0, 0);
   endtask

   initial begin
      int idle_pcts [3] = '{0, 55, 12};
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Random part in phases of sender pressure: none, heavy, light.
      for (int p = 0; p < 3; p++) begin
         while (items_sent < (p + 1) * ITEM_TARGET / 3) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(req_kind_type'(1'($urandom_range(0, 1))), $urandom,
                         1'($urandom_range(0, 1)), idle_pcts[p]);
            else
               load_and_probe(idle_pcts[p]);
         end
      end
      start <= 1'b0;

      // Drain: wait for every owed response, then watch for strays.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("** sorted_set_binary_search_unit: PASSED **");
      else
         $display("** sorted_set_binary_search_unit: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
src/ssbs_pkg.sv
src/ssbs_ram.sv
src/ssbs_ctrl.sv
src/sorted_set_binary_search_unit.sv
tb/sorted_set_binary_search_unit_test.sv
